>>> rtl/core/sfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfl_pkg: shared types and constants of the free-list placer
// Opcodes, status codes, fit modes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package sfl_pkg;
    localparam int MAX_GAPS_DEF    = 64;
    localparam int MAX_ITEMS_DEF   = 256;
    localparam int OFFSET_BITS_DEF = 32;

    localparam logic       OP_PLACE = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] FM_FIRST = 2'd0;
    localparam logic [1:0] FM_BEST  = 2'd1;
    localparam logic [1:0] FM_TWO   = 2'd2;

    localparam logic       REG_FIT_MODE  = 1'b0;
    localparam logic       REG_THRESHOLD = 1'b1;

    typedef logic [31:0] t_word;
endpackage
`default_nettype wire

>>> rtl/core/sfl_gap_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfl_gap_mem: gap table storage
// One write port and one registered read port holding {start, length}.
// ----------------------------------------------------------------------------
module sfl_gap_mem #(
    parameter int AW = 6,
    parameter int DW = 65
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/sweep_free_list_placer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sweep_free_list_placer: coalescing free-list allocator
// Address-ordered gap table with first-fit / best-fit placement.
// ----------------------------------------------------------------------------
// Usage: requests (opcode, item_id, alloc_size) enter on i_valid/o_ready; one
// result (placed_offset, status) leaves per request on o_valid/i_ready.
// Configuration writes (i_cfg_index 0 fit_mode, 1 size_threshold) use
// i_cfg_valid/o_cfg_ready; write them only while no request is in flight.
// One request at a time is processed by a sequencer around the gap-table
// RAM (one write port, one registered read port). Every gap read is an
// address step then a compare step; every entry moved is a read step then
// a write step. A place scans every gap for best-fit or no fit (first-fit
// stops at the first fitting gap); an exact fit then removes its gap by
// moving the later entries down. A free reads the item offset, scans to
// the insertion point, then merges, inserts or removes.
// Reset writes the whole-space gap into entry 0 and sets the count to one;
// other entries are only read below the count, so no clearing pass.
// The result waits in an output register while the receiver stalls; a new
// request is accepted the cycle after that register is emptied.
// ----------------------------------------------------------------------------
module sweep_free_list_placer #(
    parameter int MAX_GAPS    = sfl_pkg::MAX_GAPS_DEF,
    parameter int MAX_ITEMS   = sfl_pkg::MAX_ITEMS_DEF,
    parameter int OFFSET_BITS = sfl_pkg::OFFSET_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire sfl_pkg::t_word     i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_opcode,
    input  wire logic [7:0]         i_item_id,
    input  wire sfl_pkg::t_word     i_alloc_size,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output sfl_pkg::t_word          o_placed_offset,
    output logic [1:0]              o_status
);
    import sfl_pkg::*;

    localparam int GW = $clog2(MAX_GAPS);
    localparam int CW = $clog2(MAX_GAPS + 1);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int OB = OFFSET_BITS;
    localparam int LB = OFFSET_BITS + 1;
    localparam int DW = OB + LB;
    localparam logic [LB-1:0] SPACE = {1'b1, {OB{1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_PLACE = 4'd3;
    localparam logic [3:0] S_ITEM  = 4'd4;
    localparam logic [3:0] S_FREE  = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FCMP  = 4'd7;
    localparam logic [3:0] S_PRV   = 4'd8;
    localparam logic [3:0] S_DEC   = 4'd9;
    localparam logic [3:0] S_DNRD  = 4'd10;
    localparam logic [3:0] S_DNWR  = 4'd11;
    localparam logic [3:0] S_UPRD  = 4'd12;
    localparam logic [3:0] S_UPWR  = 4'd13;

    logic [3:0]      r_state;
    logic [1:0]      r_fit_mode;
    t_word           r_threshold;
    logic [CW-1:0]   r_count;
    logic            r_op;
    logic [IW-1:0]   r_id;
    logic [LB-1:0]   r_size;
    logic            r_best;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_pick;
    logic            r_found;
    logic [OB-1:0]   r_pstart;
    logic [LB-1:0]   r_plen;
    logic [OB-1:0]   r_off;
    logic [LB-1:0]   r_len;
    logic [LB-1:0]   r_nlen;
    logic            r_jnext;
    logic [CW-1:0]   r_mv;
    logic            r_ovalid;
    t_word           r_out_off;
    logic [1:0]      r_out_st;

    logic            m_we;
    logic [GW-1:0]   m_waddr;
    logic [DW-1:0]   m_wdata;
    logic [GW-1:0]   m_raddr;
    logic [DW-1:0]   m_rdata;
    logic [OB-1:0]   rd_start;
    logic [LB-1:0]   rd_len;

    logic [OB-1:0]   r_item_mem [MAX_ITEMS];
    logic [OB-1:0]   r_item_rd;

    sfl_gap_mem #(.AW(GW), .DW(DW)) u_gaps (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign rd_start = m_rdata[DW-1 -: OB];
    assign rd_len   = m_rdata[LB-1:0];

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid         = r_ovalid;
    assign o_placed_offset = r_out_off;
    assign o_status        = r_out_st;

    // item offset store: write on a successful place, read in S_ITEM
    always_ff @(posedge i_clk) begin
        if (r_state == S_PLACE && r_op == OP_PLACE && r_found) begin
            r_item_mem[r_id] <= r_pstart;
        end
        r_item_rd <= r_item_mem[r_id];
    end

    logic [LB-1:0] end_sum;
    logic [LB-1:0] avail;
    logic          jprev;
    always_comb begin
        end_sum = {1'b0, r_off} + r_len;
        avail   = SPACE - {1'b0, r_item_rd};
        // previous gap ends exactly where the freed region starts
        jprev   = r_idx != '0 && ({1'b0, rd_start} + rd_len) == {1'b0, r_off};
    end

    // memory port control
    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_idx[GW-1:0];
        m_wdata = {r_off, r_len};
        m_raddr = r_idx[GW-1:0];
        if (!i_rst_n) begin
            // load the whole-space gap into entry 0
            m_we    = 1'b1;
            m_waddr = '0;
            m_wdata = {{OB{1'b0}}, SPACE};
        end else begin
            unique case (r_state)
                S_PLACE: begin
                    m_we    = r_found && r_size != '0 && r_plen != r_size;
                    m_waddr = r_pick[GW-1:0];
                    m_wdata = {r_pstart + r_size[OB-1:0], r_plen - r_size};
                end
                S_PRV: m_raddr = GW'(r_idx - 1'b1);
                S_DEC: begin
                    if (jprev) begin
                        m_we    = 1'b1;
                        m_waddr = GW'(r_idx - 1'b1);
                        m_wdata = {rd_start, rd_len + r_len + (r_jnext ? r_nlen : '0)};
                    end else if (r_jnext) begin
                        m_we    = 1'b1;
                        m_wdata = {r_off, r_nlen + r_len};
                    end
                end
                S_DNRD: m_raddr = r_mv[GW-1:0];
                S_DNWR: begin
                    m_we    = 1'b1;
                    m_waddr = GW'(r_mv - 1'b1);
                    m_wdata = m_rdata;
                end
                S_UPRD: begin
                    // drop the new gap in once the hole reaches its slot
                    m_raddr = GW'(r_mv - 1'b1);
                    m_we    = r_mv == r_idx;
                end
                S_UPWR: begin
                    m_we    = 1'b1;
                    m_waddr = r_mv[GW-1:0];
                    m_wdata = m_rdata;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fit_mode  <= FM_FIRST;
            r_threshold <= '0;
            r_count     <= CW'(1);
            r_ovalid    <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_FIT_MODE) r_fit_mode <= i_cfg_data[1:0];
                else r_threshold <= i_cfg_data;
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op    <= i_opcode;
                        r_id    <= IW'(i_item_id);
                        r_size  <= LB'(i_alloc_size);
                        r_best  <= r_fit_mode == FM_BEST ||
                                   (r_fit_mode == FM_TWO && i_alloc_size < r_threshold);
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= (i_opcode == OP_PLACE) ? S_RD : S_ITEM;
                    end
                end
                S_RD: begin
                    // read of entry r_idx issued this cycle
                    r_state <= (r_idx >= r_count) ? S_PLACE : S_SCAN;
                end
                S_SCAN: begin
                    if (rd_len >= r_size &&
                        (!r_found || (r_best && rd_len < r_plen))) begin
                        r_found  <= 1'b1;
                        r_pick   <= r_idx;
                        r_pstart <= rd_start;
                        r_plen   <= rd_len;
                    end
                    if (rd_len >= r_size && !r_best) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_PLACE: begin
                    if (!r_found) begin
                        r_out_off <= '0;
                        r_out_st  <= ST_NOFIT;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_out_off <= 32'(r_pstart);
                        r_out_st  <= ST_OK;
                        if (r_size != '0 && r_plen == r_size) begin
                            r_mv    <= r_pick + 1'b1;
                            r_state <= S_DNRD;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_ITEM: r_state <= S_FREE;
                S_FREE: begin
                    // clip to the end of the space, then scan from entry 0
                    r_off     <= r_item_rd;
                    r_out_off <= 32'(r_item_rd);
                    r_out_st  <= ST_OK;
                    r_len     <= (r_size > avail) ? avail : r_size;
                    r_idx     <= '0;
                    if (r_size == '0) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    if (r_idx >= r_count) begin
                        r_jnext <= 1'b0;
                        r_state <= S_PRV;
                    end else begin
                        r_state <= S_FCMP;
                    end
                end
                S_FCMP: begin
                    // stop at the first gap starting at or above the offset
                    if (rd_start < r_off) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_FRD;
                    end else begin
                        r_jnext <= {1'b0, rd_start} == end_sum;
                        r_nlen  <= rd_len;
                        r_state <= S_PRV;
                    end
                end
                S_PRV: r_state <= S_DEC;
                S_DEC: begin
                    if (jprev && r_jnext) begin
                        r_mv    <= r_idx + 1'b1;
                        r_state <= S_DNRD;
                    end else if (jprev || r_jnext) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_count >= CW'(MAX_GAPS)) begin
                        r_out_st <= ST_FULL;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_mv    <= r_count;
                        r_state <= S_UPRD;
                    end
                end
                S_DNRD: begin
                    if (r_mv >= r_count) begin
                        r_count  <= r_count - 1'b1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_DNWR;
                    end
                end
                S_DNWR: begin
                    // entry r_mv moved to r_mv-1
                    r_mv    <= r_mv + 1'b1;
                    r_state <= S_DNRD;
                end
                S_UPRD: begin
                    if (r_mv == r_idx) begin
                        r_count  <= r_count + 1'b1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_UPWR;
                    end
                end
                S_UPWR: begin
                    // entry r_mv-1 moved to r_mv
                    r_mv    <= r_mv - 1'b1;
                    r_state <= S_UPRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_placed_offset) && $stable(o_status))
        else $error("result changed while stalled");
    a_no_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_GAPS))
        else $error("gap count overflow");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NOFIT || o_status == ST_FULL))
        else $error("illegal status");
    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_UPWR)
        else $error("illegal state");
endmodule
`default_nettype wire

>>> bench/sweep_free_list_placer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_free_list_placer_tb: self-checking bench for the free-list placer
// Drives place and free requests with random gaps, predicts each result from
// a behavioral copy of the gap table, and compares offset and status in order.
// ----------------------------------------------------------------------------
module sweep_free_list_placer_tb;
    import sfl_pkg::*;

    localparam int NGAPS  = MAX_GAPS_DEF;
    localparam int NITEMS = MAX_ITEMS_DEF;
    localparam int WDOG   = 20000;

    typedef struct packed {
        t_word      offset;
        logic [1:0] status;
    } t_outcome;

    class placer_scoreboard;
        logic [32:0] gstart [NGAPS];
        logic [32:0] glen [NGAPS];
        int          gcount;
        logic [31:0] ioff [NITEMS];
        logic [1:0]  mode;
        t_word       thresh;
        t_outcome    pending [$];
        int          errors;
        int          checked;

        function void clear();
            gcount = 1;
            gstart[0] = 0;
            glen[0] = 33'h1_0000_0000;
            mode = FM_FIRST;
            thresh = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void drop_gap(int i);
            for (int k = i; k + 1 < gcount; k++) begin
                gstart[k] = gstart[k + 1];
                glen[k] = glen[k + 1];
            end
            gcount--;
        endfunction

        function logic [1:0] release_region(logic [32:0] off, logic [32:0] len);
            int p;
            bit jn, jp;
            p = 0;
            if (len > 33'h1_0000_0000 - off) len = 33'h1_0000_0000 - off;
            if (len == 0) return ST_OK;
            while (p < gcount && gstart[p] < off) p++;
            jn = p < gcount && gstart[p] == off + len;
            jp = p > 0 && gstart[p - 1] + glen[p - 1] == off;
            if (jp && jn) begin
                glen[p - 1] += len + glen[p];
                drop_gap(p);
            end else if (jp) begin
                glen[p - 1] += len;
            end else if (jn) begin
                gstart[p] = off;
                glen[p] += len;
            end else begin
                if (gcount >= NGAPS) return ST_FULL;
                for (int k = gcount; k > p; k--) begin
                    gstart[k] = gstart[k - 1];
                    glen[k] = glen[k - 1];
                end
                gstart[p] = off;
                glen[p] = len;
                gcount++;
            end
            return ST_OK;
        endfunction

        function void note_request(logic op, logic [7:0] id, t_word size);
            t_outcome r;
            bit best;
            int g;
            r.offset = 0;
            r.status = ST_OK;
            if (op == OP_PLACE) begin
                best = mode == FM_BEST || (mode == FM_TWO && size < thresh);
                g = gcount;
                for (int i = 0; i < gcount; i++) begin
                    if (glen[i] >= {1'b0, size}) begin
                        if (!best) begin
                            g = i;
                            break;
                        end
                        if (g == gcount || glen[i] < glen[g]) g = i;
                    end
                end
                if (g >= gcount) begin
                    r.status = ST_NOFIT;
                end else begin
                    r.offset = gstart[g][31:0];
                    if (size != 0) begin
                        if (glen[g] == {1'b0, size}) drop_gap(g);
                        else begin
                            gstart[g] += size;
                            glen[g] -= size;
                        end
                    end
                    ioff[id] = r.offset;
                end
            end else begin
                r.offset = ioff[id];
                r.status = release_region({1'b0, ioff[id]}, {1'b0, size});
            end
            pending = {pending, r};
        endfunction

        function void check_result(t_word off, logic [1:0] st);
            t_outcome e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result off=%h st=%0d", off, st);
                return;
            end
            e = pending.pop_front();
            if (e.offset !== off || e.status !== st) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: exp off=%h st=%0d got off=%h st=%0d",
                             checked, e.offset, e.status, off, st);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    t_word      i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic       i_opcode;
    logic [7:0] i_item_id;
    t_word      i_alloc_size;
    logic       o_valid;
    logic       i_ready;
    t_word      o_placed_offset;
    logic [1:0] o_status;

    placer_scoreboard sb;
    int  idle_cycles;
    int  results_seen;
    bit  live [NITEMS];
    t_word live_size [NITEMS];

    sweep_free_list_placer dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("watchdog expired");
            $display("sweep_free_list_placer_tb: errors");
            $finish;
        end
    end

    // receiver with random stalls
    initial begin
        int wait_n;
        i_ready = 0;
        results_seen = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_n = $urandom_range(3) == 0 ? 0 : $urandom_range(14);
            if (wait_n != 0) begin
                i_ready <= 0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk iff o_valid);
            sb.check_result(o_placed_offset, o_status);
            results_seen++;
        end
    end

    task automatic write_reg(logic idx, t_word val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == REG_FIT_MODE) sb.mode = val[1:0];
        else sb.thresh = val;
        @(posedge i_clk);
    endtask

    task automatic send_request(logic op, logic [7:0] id, t_word size, bit gaps);
        if (gaps) repeat ($urandom_range(14)) @(posedge i_clk);
        i_valid      <= 1;
        i_opcode     <= op;
        i_item_id    <= id;
        i_alloc_size <= size;
        @(posedge i_clk iff o_ready);
        sb.note_request(op, id, size);
        i_valid <= 0;
        if (op == OP_PLACE && sb.pending[$].status == ST_OK) begin
            live[id] = 1;
            live_size[id] = size;
        end else if (op == OP_FREE) begin
            live[id] = 0;
        end
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * NGAPS + 20) @(posedge i_clk);
    endtask

    function automatic t_word pick_size();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            3, 4: return $urandom_range(4096, 1);
            default: return $urandom_range(64, 1);
        endcase
    endfunction

    // random phase: mostly place/free of tracked items, some oversized frees
    task automatic random_phase(int n, bit gaps);
        logic [7:0] id;
        for (int k = 0; k < n; k++) begin
            id = $urandom_range(NITEMS - 1);
            if (live[id] && $urandom_range(2) != 0)
                send_request(OP_FREE, id, $urandom_range(15) == 0 ?
                             32'hFFFF_FFFF : live_size[id], gaps);
            else if (!live[id])
                send_request(OP_PLACE, id, pick_size(), gaps);
            else
                k--;
        end
    endtask

    initial begin
        bit gaps;
        sb = new();
        sb.clear();
        i_rst_n      = 0;
        i_cfg_valid  = 0;
        i_cfg_index  = REG_FIT_MODE;
        i_cfg_data   = 0;
        i_valid      = 0;
        i_opcode     = OP_PLACE;
        i_item_id    = 0;
        i_alloc_size = 0;
        idle_cycles  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero size, whole space, no fit, coalescing, table full
        send_request(OP_PLACE, 8'd0, 32'd0, 0);
        send_request(OP_PLACE, 8'd1, 32'hFFFF_FFFF, 0);
        send_request(OP_PLACE, 8'd2, 32'd2, 0);
        send_request(OP_PLACE, 8'd3, 32'd1, 0);
        send_request(OP_PLACE, 8'd4, 32'd0, 0);
        send_request(OP_FREE,  8'd1, 32'hFFFF_FFFF, 0);
        send_request(OP_FREE,  8'd3, 32'd1, 0);
        send_request(OP_FREE,  8'd0, 32'd0, 0);
        for (int i = 0; i < 2 * NGAPS + 4; i++)
            send_request(OP_PLACE, 8'(16 + i), 32'd1, 0);
        for (int i = 0; i < 2 * NGAPS + 4; i += 2)
            send_request(OP_FREE, 8'(16 + i), 32'd1, 0);
        send_request(OP_PLACE, 8'hFF, 32'h8000_0000, 0);
        drain();
        foreach (live[i]) live[i] = 0;
        for (int i = 0; i < NITEMS; i++)
            if (i >= 16 && i < 16 + 2 * NGAPS + 4 && (i % 2) == 1) begin
                live[i] = 1;
                live_size[i] = 1;
            end

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_FIT_MODE, ph < 4 ? 2'(ph) : 2'($urandom_range(3)));
            case (ph % 4)
                0: write_reg(REG_THRESHOLD, 32'd0);
                1: write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
                default: write_reg(REG_THRESHOLD, $urandom_range(128));
            endcase
            gaps = (ph % 3) != 2;
            random_phase(140, gaps);
            drain();
        end

        $display("covered %0d results over all fit modes and threshold extremes",
                 results_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sweep_free_list_placer_tb: clean");
        else
            $display("sweep_free_list_placer_tb: errors");
        $finish;
    end
endmodule
